@@ rtl/palette_fade_sequencer_macros.svh @@
`ifndef PALETTE_FADE_SEQUENCER_MACROS_SVH
`define PALETTE_FADE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define PFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pfs_pkg.sv @@
package pfs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_FOR_KEY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOUND_CODE   = 2'd2;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  localparam logic [1:0] PH_FADE_IN  = 2'd0;
  localparam logic [1:0] PH_HOLD     = 2'd1;
  localparam logic [1:0] PH_FADE_OUT = 2'd2;
  localparam logic [1:0] PH_DONE     = 2'd3;

  localparam logic [7:0]  FADE_STEP   = 8'd8;
  localparam logic [15:0] SOUND_FRAME = 16'd32;
  localparam logic [15:0] FC_MAX      = 16'hFFFF;
  localparam logic [15:0] HOLD_RESET  = 16'd60;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] entry_index;
    logic [7:0] target_red;
    logic [7:0] target_green;
    logic [7:0] target_blue;
    logic       key_pressed;
  } in_t;

  typedef struct packed {
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
    logic [1:0] phase;
    logic       play_sound;
    logic [7:0] sound_to_play;
  } out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_FADE_IN  = 2'd1,
    OP_FADE_OUT = 2'd2
  } dp_op_e;

  typedef struct packed {
    logic   start;
    dp_op_e op;
    logic   rd_en;
    logic   tgt_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic all_zero;
  } dp_stat_t;

  typedef struct packed {
    logic       load;
    logic       show;
    logic [1:0] phase;
    logic       play;
    logic [7:0] code;
  } res_t;

endpackage

@@ rtl/pfs_datapath.sv @@
module pfs_datapath #(
  parameter int ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfs_pkg::dp_cmd_t  cmd_i,
  input  logic [7:0]        idx_i,
  input  pfs_pkg::rgb_t     tgt_color_i,
  output pfs_pkg::dp_stat_t stat_o,
  output pfs_pkg::rgb_t     rd_color_o
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  pfs_pkg::rgb_t wrk_mem [ENTRIES];
  pfs_pkg::rgb_t tgt_mem [ENTRIES];

  logic               act_q;
  pfs_pkg::dp_op_e    op_q;
  logic [IDX_W-1:0]   wa_q;
  logic               s1_v_q;
  logic               s1_last_q;
  logic [IDX_W-1:0]   s1_addr_q;
  logic               az_q;
  pfs_pkg::rgb_t      wrk_rd_q;
  pfs_pkg::rgb_t      tgt_rd_q;

  logic [IDX_W+7:0]   idx_wide;
  logic [IDX_W-1:0]   idx_addr;
  logic               clr_act;
  logic               fade_act;
  logic               rd_do;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  pfs_pkg::rgb_t      wr_data;
  pfs_pkg::rgb_t      new_color;
  logic               cur_zero;

  function automatic logic [7:0] step_up(input logic [7:0] cur, input logic [7:0] tgt);
    logic [8:0] sum;
    sum = {1'b0, cur} + {1'b0, pfs_pkg::FADE_STEP};
    if (cur < tgt) begin
      if (sum > {1'b0, tgt}) begin
        return tgt;
      end
      return sum[7:0];
    end
    return cur;
  endfunction

  function automatic logic [7:0] step_down(input logic [7:0] cur);
    if (cur > pfs_pkg::FADE_STEP) begin
      return cur - pfs_pkg::FADE_STEP;
    end
    return 8'd0;
  endfunction

  assign idx_wide = {{IDX_W{1'b0}}, idx_i};
  assign idx_addr = idx_wide[IDX_W-1:0];

  assign clr_act  = act_q && (op_q == pfs_pkg::OP_CLEAR);
  assign fade_act = act_q && (op_q != pfs_pkg::OP_CLEAR);
  assign rd_do    = cmd_i.rd_en || fade_act;
  assign rd_addr  = cmd_i.rd_en ? idx_addr : wa_q;

  always_comb begin
    if (op_q == pfs_pkg::OP_FADE_IN) begin
      new_color.red   = step_up(wrk_rd_q.red, tgt_rd_q.red);
      new_color.green = step_up(wrk_rd_q.green, tgt_rd_q.green);
      new_color.blue  = step_up(wrk_rd_q.blue, tgt_rd_q.blue);
    end else begin
      new_color.red   = step_down(wrk_rd_q.red);
      new_color.green = step_down(wrk_rd_q.green);
      new_color.blue  = step_down(wrk_rd_q.blue);
    end
  end

  assign wr_en    = clr_act || s1_v_q;
  assign wr_addr  = clr_act ? wa_q : s1_addr_q;
  assign wr_data  = clr_act ? '0 : new_color;
  assign cur_zero = (wrk_rd_q == '0);

  assign stat_o.done     = (clr_act && (wa_q == LAST)) || (s1_v_q && s1_last_q);
  assign stat_o.all_zero = az_q && cur_zero;
  assign rd_color_o      = wrk_rd_q;

  always_ff @(posedge clk_i) begin
    if (rd_do) begin
      wrk_rd_q <= wrk_mem[rd_addr];
      tgt_rd_q <= tgt_mem[rd_addr];
    end
    if (wr_en) begin
      wrk_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.tgt_wr) begin
      tgt_mem[idx_addr] <= tgt_color_i;
    end
  end

  // sweep control, reset starts a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b1;
      op_q      <= pfs_pkg::OP_CLEAR;
      wa_q      <= '0;
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      s1_addr_q <= '0;
      az_q      <= 1'b1;
    end else begin
      s1_v_q    <= fade_act;
      s1_last_q <= fade_act && (wa_q == LAST);
      s1_addr_q <= wa_q;
      if (cmd_i.start) begin
        act_q <= 1'b1;
        op_q  <= cmd_i.op;
        wa_q  <= '0;
        az_q  <= 1'b1;
      end else begin
        if (act_q) begin
          if (wa_q == LAST) begin
            act_q <= 1'b0;
          end else begin
            wa_q <= wa_q + IDX_W'(1);
          end
        end
        if (s1_v_q) begin
          az_q <= az_q && cur_zero;
        end
      end
    end
  end

endmodule

@@ rtl/pfs_ctrl.sv @@
module pfs_ctrl #(
  parameter int ENTRIES = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [1:0]                       kind_i,
  input  logic [7:0]                       idx_i,
  input  logic                             key_i,
  output logic                             in_stall_o,
  input  logic                             cfg_we_i,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pfs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             out_free_i,
  input  pfs_pkg::dp_stat_t                dp_stat_i,
  output pfs_pkg::dp_cmd_t                 dp_cmd_o,
  output pfs_pkg::res_t                    res_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] fc_q, fc_d;
  logic        snd_q, snd_d;
  logic [1:0]  kind_q, kind_d;
  logic        show_q, show_d;
  logic [15:0] hold_q;
  logic        wfk_q;
  logic [7:0]  code_q;

  logic        in_range;
  logic        key_gate;
  logic [1:0]  ph_eff;
  logic [15:0] fc_inc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_range   = 32'(idx_i) < ENTRIES;
  assign key_gate   = !wfk_q || (fc_q > hold_q);
  assign ph_eff     = (key_i && key_gate) ? pfs_pkg::PH_FADE_OUT : phase_q;
  assign fc_inc     = (fc_q == pfs_pkg::FC_MAX) ? fc_q : fc_q + 16'd1;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    fc_d     = fc_q;
    snd_d    = snd_q;
    kind_d   = kind_q;
    show_d   = show_q;
    dp_cmd_o = '{start: 1'b0, op: pfs_pkg::OP_CLEAR, rd_en: 1'b0, tgt_wr: 1'b0};
    res_o.load  = 1'b0;
    res_o.show  = show_q;
    res_o.phase = phase_q;
    res_o.play  = snd_q;
    res_o.code  = snd_q ? code_q : 8'd0;
    case (state_q)
      S_CLEAR: begin
        if (dp_stat_i.done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          show_d  = (kind_i == pfs_pkg::KIND_READ) && in_range;
          snd_d   = 1'b0;
          state_d = S_EMIT;
          case (kind_i)
            pfs_pkg::KIND_LOAD: begin
              dp_cmd_o.tgt_wr = in_range;
            end
            pfs_pkg::KIND_READ: begin
              dp_cmd_o.rd_en = in_range;
            end
            pfs_pkg::KIND_RESTART: begin
              phase_d = pfs_pkg::PH_FADE_IN;
              fc_d    = '0;
            end
            default: begin
              if (phase_q != pfs_pkg::PH_DONE) begin
                phase_d = ph_eff;
                fc_d    = fc_inc;
                if (ph_eff == pfs_pkg::PH_FADE_IN) begin
                  dp_cmd_o.start = 1'b1;
                  dp_cmd_o.op    = pfs_pkg::OP_FADE_IN;
                  state_d        = S_WALK;
                  snd_d          = (fc_inc == pfs_pkg::SOUND_FRAME);
                  if (fc_inc > pfs_pkg::SOUND_FRAME) begin
                    phase_d = pfs_pkg::PH_HOLD;
                    fc_d    = '0;
                  end
                end else if (ph_eff == pfs_pkg::PH_HOLD) begin
                  if ((fc_inc > hold_q) && !wfk_q) begin
                    phase_d = pfs_pkg::PH_FADE_OUT;
                    fc_d    = '0;
                  end
                end else begin
                  fc_d           = '0;
                  dp_cmd_o.start = 1'b1;
                  dp_cmd_o.op    = pfs_pkg::OP_FADE_OUT;
                  state_d        = S_WALK;
                end
              end
            end
          endcase
        end
      end
      S_WALK: begin
        if (dp_stat_i.done) begin
          state_d = S_EMIT;
          if ((phase_q == pfs_pkg::PH_FADE_OUT) && dp_stat_i.all_zero) begin
            phase_d = pfs_pkg::PH_DONE;
          end
        end
      end
      S_EMIT: begin
        if (out_free_i) begin
          res_o.load = 1'b1;
          if (kind_q == pfs_pkg::KIND_RESTART) begin
            dp_cmd_o.start = 1'b1;
            dp_cmd_o.op    = pfs_pkg::OP_CLEAR;
            state_d        = S_CLEAR;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      phase_q <= pfs_pkg::PH_FADE_IN;
      fc_q    <= '0;
      snd_q   <= 1'b0;
      kind_q  <= pfs_pkg::KIND_LOAD;
      show_q  <= 1'b0;
      hold_q  <= pfs_pkg::HOLD_RESET;
      wfk_q   <= 1'b0;
      code_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fc_q    <= fc_d;
      snd_q   <= snd_d;
      kind_q  <= kind_d;
      show_q  <= show_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          pfs_pkg::REG_HOLD_FRAMES:  hold_q <= cfg_wdata_i;
          pfs_pkg::REG_WAIT_FOR_KEY: wfk_q  <= cfg_wdata_i[0];
          pfs_pkg::REG_SOUND_CODE:   code_q <= cfg_wdata_i[7:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/palette_fade_sequencer.sv @@
// load, read, and ticks in the finished or hold phase with no key press taken: S_IDLE to S_EMIT,
// result word registered once the output is free, then back to S_IDLE for the next accept
// fade ticks: a sweep in S_WALK, one palette entry per cycle through the working memory
// restart: result word from S_EMIT, then a clearing sweep in S_CLEAR before the next accept
// reset: clearing sweep of the working palette with in_stall_o high;
// config writes are taken throughout
module palette_fade_sequencer #(
  parameter int ENTRIES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pfs_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pfs_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pfs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  pfs_pkg::dp_cmd_t  dp_cmd;
  pfs_pkg::dp_stat_t dp_stat;
  pfs_pkg::res_t     res;
  pfs_pkg::rgb_t     rd_color;
  pfs_pkg::rgb_t     tgt_color;

  logic          out_valid_q, out_valid_d;
  pfs_pkg::out_t out_q, out_d;
  logic          out_free;

  assign tgt_color.red   = in_data_i.target_red;
  assign tgt_color.green = in_data_i.target_green;
  assign tgt_color.blue  = in_data_i.target_blue;

  pfs_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (in_data_i.kind),
    .idx_i       (in_data_i.entry_index),
    .key_i       (in_data_i.key_pressed),
    .in_stall_o  (in_stall_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_free_i  (out_free),
    .dp_stat_i   (dp_stat),
    .dp_cmd_o    (dp_cmd),
    .res_o       (res)
  );

  pfs_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .idx_i       (in_data_i.entry_index),
    .tgt_color_i (tgt_color),
    .stat_o      (dp_stat),
    .rd_color_o  (rd_color)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d               = out_q;
    out_valid_d         = out_valid_q && !out_free;
    if (res.load) begin
      out_valid_d         = 1'b1;
      out_d.read_red      = res.show ? rd_color.red : 8'd0;
      out_d.read_green    = res.show ? rd_color.green : 8'd0;
      out_d.read_blue     = res.show ? rd_color.blue : 8'd0;
      out_d.phase         = res.phase;
      out_d.play_sound    = res.play;
      out_d.sound_to_play = res.code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/pfs_checker.sv @@
`include "palette_fade_sequencer_macros.svh"

module pfs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input pfs_pkg::out_t out_data_o
);

  `PFS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "result word dropped or changed under stall")
  `PFS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input taken again right after an accept")
  `PFS_ASSERT_NOW(a_sound_phase, out_valid_o && out_data_o.play_sound, out_data_o.phase == pfs_pkg::PH_FADE_IN, "sound request outside fade-in")
  `PFS_ASSERT_NOW(a_sound_code, out_valid_o && !out_data_o.play_sound, out_data_o.sound_to_play == 8'd0, "sound number without request")

endmodule

bind palette_fade_sequencer pfs_checker u_pfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
